[rtl/ugbt_pkg.sv]
// Constants, codes and interface types of the uniform grid bucket table.
`default_nettype none
package ugbt_pkg;

	localparam int WINDOW_W       = 1024;
	localparam int WINDOW_H       = 768;
	localparam int CELL_SIZE      = 64;
	localparam int SLOTS_PER_CELL = 16;
	localparam int MAX_OBJECTS    = 256;

	localparam int GRID_X    = (WINDOW_W + CELL_SIZE - 1) / CELL_SIZE;
	localparam int GRID_Y    = (WINDOW_H + CELL_SIZE - 1) / CELL_SIZE;
	localparam int NUM_CELLS = GRID_X * GRID_Y;

	localparam int ACTION_W  = 2;
	localparam int OBJ_W     = 8;
	localparam int POS_W     = 12;
	localparam int PIX_W     = POS_W - 1;
	localparam int CELL_W    = 8;
	localparam int SLOTIDX_W = 4;
	localparam int STATUS_W  = 2;

	localparam int OBJ_DEPTH  = (MAX_OBJECTS < (1 << OBJ_W)) ? MAX_OBJECTS : (1 << OBJ_W);
	localparam int OBJ_IDX_W  = (OBJ_DEPTH > 1) ? $clog2(OBJ_DEPTH) : 1;
	localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int COL_W      = (GRID_X > 1) ? $clog2(GRID_X) : 1;
	localparam int ROW_W      = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
	localparam int SLOT_W     = $clog2(SLOTS_PER_CELL);
	localparam int CNT_W      = $clog2(SLOTS_PER_CELL + 1);
	localparam int SLOT_DEPTH = NUM_CELLS * SLOTS_PER_CELL;
	localparam int SADDR_W    = $clog2(SLOT_DEPTH);

	localparam int RECIP_K = 22;
	localparam int RECIP   = ((1 << RECIP_K) + CELL_SIZE - 1) / CELL_SIZE;
	localparam int RECIP_W = $clog2(RECIP + 1);

	localparam logic [ACTION_W-1:0] ACT_INS_POS  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_CELL = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd3;

	typedef struct packed {
		logic                  own_rd_en;
		logic [OBJ_IDX_W-1:0]  own_rd_addr;
		logic                  cnt_rd_en;
		logic [CELL_IDX_W-1:0] cnt_rd_cell;
		logic                  slot_rd_en;
		logic [SADDR_W-1:0]    slot_rd_addr;
		logic                  slot_wr_en;
		logic [SADDR_W-1:0]    slot_wr_addr;
		logic [OBJ_W-1:0]      slot_wr_data;
		logic                  cnt_wr_en;
		logic [CELL_IDX_W-1:0] cnt_wr_cell;
		logic [CNT_W-1:0]      cnt_wr_data;
		logic                  own_wr_en;
		logic [OBJ_IDX_W-1:0]  own_wr_addr;
		logic [CELL_IDX_W-1:0] own_wr_cell;
		logic [SLOT_W-1:0]     own_wr_slot;
		logic                  pres_wr_en;
		logic [OBJ_IDX_W-1:0]  pres_wr_addr;
		logic                  pres_wr_val;
	} tbl_cmd_t;

	typedef struct packed {
		logic [CELL_IDX_W-1:0] own_cell;
		logic [SLOT_W-1:0]     own_slot;
		logic                  present;
		logic [CNT_W-1:0]      cnt;
		logic [OBJ_W-1:0]      slot_data;
	} tbl_rsp_t;

	function automatic logic [SADDR_W-1:0] slot_addr(input logic [CELL_IDX_W-1:0] cell_no,
		input logic [CNT_W-1:0] slot);
		slot_addr = SADDR_W'(int'(cell_no) * SLOTS_PER_CELL + int'(slot));
	endfunction

endpackage
`default_nettype wire

[rtl/ugbt_cell_map.sv]
// Registered mapping of a pixel position to grid column, row and window test.
`default_nettype none
module ugbt_cell_map (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [ugbt_pkg::POS_W-1:0] pos_x,
	input  wire logic [ugbt_pkg::POS_W-1:0] pos_y,
	output logic [ugbt_pkg::COL_W-1:0]     col_s1,
	output logic [ugbt_pkg::ROW_W-1:0]     row_s1,
	output logic                           in_win_s1
);
	import ugbt_pkg::*;

	localparam int PROD_W = PIX_W + RECIP_W;

	logic [PROD_W-1:0] prod_x, prod_y;
	logic [PIX_W-1:0]  quot_x, quot_y;
	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic              in_win;

	always_comb begin
		prod_x = PROD_W'(pos_x[PIX_W-1:0]) * PROD_W'(RECIP);
		prod_y = PROD_W'(pos_y[PIX_W-1:0]) * PROD_W'(RECIP);
		quot_x = PIX_W'(prod_x >> RECIP_K);
		quot_y = PIX_W'(prod_y >> RECIP_K);
		col = (int'(quot_x) >= GRID_X) ? COL_W'(GRID_X - 1) : COL_W'(quot_x);
		row = (int'(quot_y) >= GRID_Y) ? ROW_W'(GRID_Y - 1) : ROW_W'(quot_y);
		in_win = !pos_x[POS_W-1] && !pos_y[POS_W-1]
			&& (int'(pos_x[PIX_W-1:0]) < WINDOW_W)
			&& (int'(pos_y[PIX_W-1:0]) < WINDOW_H);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1    <= col;
			row_s1    <= row;
			in_win_s1 <= in_win;
		end
	end
endmodule
`default_nettype wire

[rtl/ugbt_tables.sv]
// Slot, count and owner memories with count valid bits and presence flags.
`default_nettype none
module ugbt_tables (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ugbt_pkg::tbl_cmd_t cmd,
	output ugbt_pkg::tbl_rsp_t      rsp
);
	import ugbt_pkg::*;

	logic [OBJ_W-1:0]             slot_mem [SLOT_DEPTH];
	logic [CNT_W-1:0]             cnt_mem  [NUM_CELLS];
	logic [CELL_IDX_W+SLOT_W-1:0] own_mem  [OBJ_DEPTH];

	logic [NUM_CELLS-1:0]         cnt_vld_q;
	logic [OBJ_DEPTH-1:0]         present_q;

	logic [OBJ_W-1:0]             slot_rd_q;
	logic [CNT_W-1:0]             cnt_rd_q;
	logic                         cnt_vld_rd_q;
	logic [CELL_IDX_W+SLOT_W-1:0] own_rd_q;
	logic                         pres_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.slot_wr_en) begin
			slot_mem[cmd.slot_wr_addr] <= cmd.slot_wr_data;
		end
		if (cmd.slot_rd_en) begin
			slot_rd_q <= slot_mem[cmd.slot_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_wr_en) begin
			cnt_mem[cmd.cnt_wr_cell] <= cmd.cnt_wr_data;
		end
		if (cmd.cnt_rd_en) begin
			cnt_rd_q     <= cnt_mem[cmd.cnt_rd_cell];
			cnt_vld_rd_q <= cnt_vld_q[cmd.cnt_rd_cell];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.own_wr_en) begin
			own_mem[cmd.own_wr_addr] <= {cmd.own_wr_cell, cmd.own_wr_slot};
		end
		if (cmd.own_rd_en) begin
			own_rd_q  <= own_mem[cmd.own_rd_addr];
			pres_rd_q <= present_q[cmd.own_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			present_q <= '0;
		end else begin
			if (cmd.cnt_wr_en) begin
				cnt_vld_q[cmd.cnt_wr_cell] <= 1'b1;
			end
			if (cmd.pres_wr_en) begin
				present_q[cmd.pres_wr_addr] <= cmd.pres_wr_val;
			end
		end
	end

	always_comb begin
		rsp.own_cell  = own_rd_q[CELL_IDX_W+SLOT_W-1:SLOT_W];
		rsp.own_slot  = own_rd_q[SLOT_W-1:0];
		rsp.present   = pres_rd_q;
		rsp.cnt       = cnt_vld_rd_q ? cnt_rd_q : '0;
		rsp.slot_data = slot_rd_q;
	end
endmodule
`default_nettype wire

[rtl/uniform_grid_bucket_table.sv]
// Top level of the uniform grid bucket table: request sequencer and result register.
`default_nettype none
// A request is taken when start is high and busy is low; its result appears on the result
// ports for one cycle with done high and cannot be held off. Each request passes through
// chained reads of registered memories: the owner and presence lookup, then the cell count,
// then for a remove that moves an entry the last slot of the cell. Busy stays high until a
// request finishes: in the lookup state for an unknown id, unused action, absent remove or
// duplicate insert, in the count state for an insert or a remove without a move, and in the
// move state for a remove with a move. No clearing pass follows reset.
module uniform_grid_bucket_table (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [ugbt_pkg::ACTION_W-1:0]    action,
	input  wire logic [ugbt_pkg::OBJ_W-1:0]       object_id,
	input  wire logic [ugbt_pkg::POS_W-1:0]       pos_x,
	input  wire logic [ugbt_pkg::POS_W-1:0]       pos_y,
	input  wire logic [ugbt_pkg::CELL_W-1:0]      target_cell,
	output logic                                  done,
	output logic [ugbt_pkg::CELL_W-1:0]           cell_index,
	output logic [ugbt_pkg::SLOTIDX_W-1:0]        slot_index,
	output logic                                  moved_valid,
	output logic [ugbt_pkg::OBJ_W-1:0]            moved_object,
	output logic [ugbt_pkg::STATUS_W-1:0]         status
);
	import ugbt_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LOOK  = 2'd1;
	localparam logic [1:0] S_COUNT = 2'd2;
	localparam logic [1:0] S_MOVE  = 2'd3;

	logic [1:0]            state_q, state_d;
	logic [ACTION_W-1:0]   act_q;
	logic [OBJ_W-1:0]      obj_q;
	logic [CELL_IDX_W-1:0] tgt_q, tgt_d;
	logic [CELL_IDX_W-1:0] cell_q, cell_d;
	logic [SLOT_W-1:0]     slot_q, slot_d;
	logic [CNT_W-1:0]      last_q, last_d;

	logic                  done_q;
	logic [CELL_W-1:0]     res_cell_q;
	logic [SLOTIDX_W-1:0]  res_slot_q;
	logic                  res_mv_q;
	logic [OBJ_W-1:0]      res_mo_q;
	logic [STATUS_W-1:0]   res_st_q;

	logic                  fin;
	logic [CELL_IDX_W-1:0] fin_cell;
	logic [SLOT_W-1:0]     fin_slot;
	logic                  fin_mv;
	logic [OBJ_W-1:0]      fin_mo;
	logic [STATUS_W-1:0]   fin_st;

	logic                  accept;
	logic [COL_W-1:0]      col_s1;
	logic [ROW_W-1:0]      row_s1;
	logic                  in_win_s1;
	logic [CELL_IDX_W-1:0] pos_cell;
	logic [CNT_W-1:0]      cnt_last;
	logic [OBJ_IDX_W-1:0]  obj_idx;
	tbl_cmd_t              cmd;
	tbl_rsp_t              rsp;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign obj_idx = obj_q[OBJ_IDX_W-1:0];

	ugbt_cell_map u_cell_map (
		.clk       (clk),
		.en        (accept),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.col_s1    (col_s1),
		.row_s1    (row_s1),
		.in_win_s1 (in_win_s1)
	);

	ugbt_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	always_comb begin
		tgt_d = (int'(target_cell) >= NUM_CELLS) ? CELL_IDX_W'(NUM_CELLS - 1)
			: CELL_IDX_W'(target_cell);
		pos_cell = in_win_s1 ? CELL_IDX_W'(int'(row_s1) * GRID_X + int'(col_s1)) : '0;
		cnt_last = CNT_W'(rsp.cnt - CNT_W'(1));
	end

	always_comb begin
		state_d  = state_q;
		cell_d   = cell_q;
		slot_d   = slot_q;
		last_d   = last_q;
		fin      = 1'b0;
		fin_cell = '0;
		fin_slot = '0;
		fin_mv   = 1'b0;
		fin_mo   = '0;
		fin_st   = STAT_OK;
		cmd      = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.own_rd_en   = 1'b1;
					cmd.own_rd_addr = object_id[OBJ_IDX_W-1:0];
					state_d         = S_LOOK;
				end
			end
			S_LOOK: begin
				if (int'(obj_q) >= MAX_OBJECTS || act_q == ACT_UNUSED) begin
					fin     = 1'b1;
					fin_st  = STAT_ABSENT;
					state_d = S_IDLE;
				end else if (act_q == ACT_REMOVE) begin
					if (!rsp.present) begin
						fin     = 1'b1;
						fin_st  = STAT_ABSENT;
						state_d = S_IDLE;
					end else begin
						cell_d          = rsp.own_cell;
						slot_d          = rsp.own_slot;
						cmd.cnt_rd_en   = 1'b1;
						cmd.cnt_rd_cell = rsp.own_cell;
						state_d         = S_COUNT;
					end
				end else if (rsp.present) begin
					fin      = 1'b1;
					fin_cell = rsp.own_cell;
					fin_slot = rsp.own_slot;
					fin_st   = STAT_PRESENT;
					state_d  = S_IDLE;
				end else begin
					cell_d          = (act_q == ACT_INS_POS) ? pos_cell : tgt_q;
					cmd.cnt_rd_en   = 1'b1;
					cmd.cnt_rd_cell = cell_d;
					state_d         = S_COUNT;
				end
			end
			S_COUNT: begin
				if (act_q != ACT_REMOVE) begin
					fin      = 1'b1;
					fin_cell = cell_q;
					state_d  = S_IDLE;
					if (int'(rsp.cnt) >= SLOTS_PER_CELL) begin
						fin_st = STAT_FULL;
					end else begin
						fin_slot         = SLOT_W'(rsp.cnt);
						cmd.slot_wr_en   = 1'b1;
						cmd.slot_wr_addr = slot_addr(cell_q, rsp.cnt);
						cmd.slot_wr_data = obj_q;
						cmd.cnt_wr_en    = 1'b1;
						cmd.cnt_wr_cell  = cell_q;
						cmd.cnt_wr_data  = CNT_W'(rsp.cnt + CNT_W'(1));
						cmd.own_wr_en    = 1'b1;
						cmd.own_wr_addr  = obj_idx;
						cmd.own_wr_cell  = cell_q;
						cmd.own_wr_slot  = SLOT_W'(rsp.cnt);
						cmd.pres_wr_en   = 1'b1;
						cmd.pres_wr_addr = obj_idx;
						cmd.pres_wr_val  = 1'b1;
					end
				end else if (CNT_W'(slot_q) < cnt_last) begin
					last_d           = cnt_last;
					cmd.slot_rd_en   = 1'b1;
					cmd.slot_rd_addr = slot_addr(cell_q, cnt_last);
					state_d          = S_MOVE;
				end else begin
					fin              = 1'b1;
					fin_cell         = cell_q;
					fin_slot         = slot_q;
					cmd.cnt_wr_en    = 1'b1;
					cmd.cnt_wr_cell  = cell_q;
					cmd.cnt_wr_data  = cnt_last;
					cmd.pres_wr_en   = 1'b1;
					cmd.pres_wr_addr = obj_idx;
					cmd.pres_wr_val  = 1'b0;
					state_d          = S_IDLE;
				end
			end
			S_MOVE: begin
				fin              = 1'b1;
				fin_cell         = cell_q;
				fin_slot         = slot_q;
				fin_mv           = 1'b1;
				fin_mo           = rsp.slot_data;
				cmd.slot_wr_en   = 1'b1;
				cmd.slot_wr_addr = slot_addr(cell_q, CNT_W'(slot_q));
				cmd.slot_wr_data = rsp.slot_data;
				cmd.own_wr_en    = 1'b1;
				cmd.own_wr_addr  = rsp.slot_data[OBJ_IDX_W-1:0];
				cmd.own_wr_cell  = cell_q;
				cmd.own_wr_slot  = slot_q;
				cmd.cnt_wr_en    = 1'b1;
				cmd.cnt_wr_cell  = cell_q;
				cmd.cnt_wr_data  = last_q;
				cmd.pres_wr_en   = 1'b1;
				cmd.pres_wr_addr = obj_idx;
				cmd.pres_wr_val  = 1'b0;
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			obj_q <= object_id;
			tgt_q <= tgt_d;
		end
		cell_q <= cell_d;
		slot_q <= slot_d;
		last_q <= last_d;
		if (fin) begin
			res_cell_q <= CELL_W'(fin_cell);
			res_slot_q <= SLOTIDX_W'(fin_slot);
			res_mv_q   <= fin_mv;
			res_mo_q   <= fin_mo;
			res_st_q   <= fin_st;
		end
	end

	assign done         = done_q;
	assign cell_index   = res_cell_q;
	assign slot_index   = res_slot_q;
	assign moved_valid  = res_mv_q;
	assign moved_object = res_mo_q;
	assign status       = res_st_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

	a_move_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && moved_valid) |-> (status == STAT_OK))
		else $error("moved entry reported with a failing status");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> (slot_index == '0 && !moved_valid))
		else $error("full cell result carries a slot or a moved entry");
endmodule
`default_nettype wire
